// ----- rtl/core/bb22_pkg.sv -----
// Package for the 2x2 box filter stream: sizes, codes, the result-load bundle and channel math.
`timescale 1ns / 1ps
`default_nettype none

package bb22_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = COL_W + 1;
    localparam int HGT_W  = ROW_W + 1;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 11;
    localparam int PIX_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 12'd64;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 12'd64;
    localparam logic [2:0]       RST_CHANNEL_COUNT = 3'd4;
    localparam logic [2:0]       CC_RGBA           = 3'd4;

    // Result slots of one item, in delivery order.
    localparam int SLOT_MEAN = 0;
    localparam int SLOT_COL  = 1;
    localparam int SLOT_ROW  = 2;
    localparam int SLOTS     = 3;

    typedef struct packed {
        logic [SLOTS-1:0]   pend;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [PIX_W-1:0]   mean;
        logic [PIX_W-1:0]   upper;
        logic [PIX_W-1:0]   cur;
        logic               fdone;
    } t_load;

    // Per-channel truncated mean of four pixels.
    function automatic logic [PIX_W-1:0] mean4(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] d);
        logic [PIX_W-1:0] res;
        logic [9:0]       s;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            s = {2'b00, a[8*k +: 8]} + {2'b00, b[8*k +: 8]}
              + {2'b00, c[8*k +: 8]} + {2'b00, d[8*k +: 8]};
            res[8*k +: 8] = s[9:2];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bb22_ram.sv -----
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none

module bb22_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bb22_emit.sv -----
// Emitter: holds up to three results of one item and sends one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module bb22_emit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire bb22_pkg::t_load        i_ld,
    output logic                        o_free,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [bb22_pkg::COORD_W-1:0] o_pix_x,
    output logic [bb22_pkg::COORD_W-1:0] o_pix_y,
    output logic [7:0]                  o_res0,
    output logic [7:0]                  o_res1,
    output logic [7:0]                  o_res2,
    output logic [7:0]                  o_res3,
    output logic                        o_last_of_run,
    output logic                        o_frame_done
);
    import bb22_pkg::*;

    logic [SLOTS-1:0] r_pend;
    logic [SLOTS-1:0] n_pend;
    t_load            r_ld;
    logic [SLOTS-1:0] sel;
    logic             take;
    logic [PIX_W-1:0] pix;

    // The lowest pending slot goes out first.
    always_comb begin
        sel = '0;
        if (r_pend[SLOT_MEAN]) begin
            sel[SLOT_MEAN] = 1'b1;
        end else if (r_pend[SLOT_COL]) begin
            sel[SLOT_COL] = 1'b1;
        end else if (r_pend[SLOT_ROW]) begin
            sel[SLOT_ROW] = 1'b1;
        end
    end

    assign o_out_valid = |r_pend;
    assign take        = o_out_valid && !i_out_stall;
    assign o_free      = (r_pend == '0) ||
                         (((r_pend & (r_pend - 1'b1)) == '0) && !i_out_stall);

    always_comb begin
        n_pend = r_pend;
        if (i_load) begin
            n_pend = i_ld.pend;
        end else if (take) begin
            n_pend = r_pend & ~sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ld <= i_ld;
        end
    end

    always_comb begin
        pix     = r_ld.cur;
        o_pix_x = r_ld.px;
        o_pix_y = r_ld.py;
        if (sel[SLOT_MEAN]) begin
            pix     = r_ld.mean;
            o_pix_x = r_ld.px - 1'b1;
            o_pix_y = r_ld.py - 1'b1;
        end else if (sel[SLOT_COL]) begin
            pix     = r_ld.upper;
            o_pix_y = r_ld.py - 1'b1;
        end
    end

    assign o_res0        = pix[7:0];
    assign o_res1        = pix[15:8];
    assign o_res2        = pix[23:16];
    assign o_res3        = pix[31:24];
    assign o_last_of_run = ((r_pend & ~sel) == '0);
    assign o_frame_done  = sel[SLOT_ROW] && r_ld.fdone;

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ($countones(r_pend) <= 1))
        else $error("item loaded over undelivered results");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame end not flagged as last result of its item");

endmodule

`default_nettype wire

// ----- rtl/core/box_blur_2x2_stream_unit.sv -----
// Top level of the 2x2 box filter over a raster-order pixel stream.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_chan0..i_chan3
// output    out        o_out_valid / i_out_stall  o_pix_x, o_pix_y, o_res0..o_res3,
//                                                 o_last_of_run, o_frame_done
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// An accepted item writes the row store and reads the pixel above it in the same cycle;
// the stage holds it until the emitter is free, then its results are computed and
// loaded into the emitter, which sends one result per cycle while not stalled.
// Items are taken every cycle while each causes at most one result, unless the output
// stalls; an item with more results stalls the input while two or more are left.
// Reset clears counters, handshake state and the neighbor pixels; the row store is not
// cleared, since each entry is written in a frame before its value is used.
// A stall on the output holds the current result and, once the stage is full, the input.

module box_blur_2x2_stream_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bb22_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bb22_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_chan0,
    input  wire logic [7:0]                i_chan1,
    input  wire logic [7:0]                i_chan2,
    input  wire logic [7:0]                i_chan3,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [bb22_pkg::COORD_W-1:0]   o_pix_x,
    output logic [bb22_pkg::COORD_W-1:0]   o_pix_y,
    output logic [7:0]                     o_res0,
    output logic [7:0]                     o_res1,
    output logic [7:0]                     o_res2,
    output logic [7:0]                     o_res3,
    output logic                           o_last_of_run,
    output logic                           o_frame_done
);
    import bb22_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [2:0]       r_cfg_cc;

    // Frame position of the next item.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // Stage holding an accepted item while its upper pixel is read.
    logic               r_a_valid;
    logic [PIX_W-1:0]   r_a_cur;
    logic [COORD_W-1:0] r_a_px;
    logic [COORD_W-1:0] r_a_py;
    logic [SLOTS-1:0]   r_a_pend;
    logic               r_a_fdone;

    // Neighbors from the previous item.
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_ul;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             x_last;
    logic             y_last;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] mask;
    logic             in_acc;
    logic             load;
    logic             free;
    logic             dim_wr;
    t_load            ld;

    // Zero dimensions count as one; larger ones saturate at the store limits.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WID_W'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HGT_W'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(r_cfg_h);
        end
    end

    assign x      = ({1'b0, r_col} >= w_eff) ? '0 : r_col;
    assign y      = ({1'b0, r_row} >= h_eff) ? '0 : r_row;
    assign x_last = (({1'b0, x} + 1'b1) == w_eff);
    assign y_last = (({1'b0, y} + 1'b1) == h_eff);

    // Unless the count is RGBA, the fourth channel is dropped both going in and going out.
    assign mask = (r_cfg_cc == CC_RGBA) ? '1 : {8'h00, 24'hFF_FFFF};
    assign cur  = {i_chan3, i_chan2, i_chan1, i_chan0} & mask;

    assign load       = r_a_valid && free;
    assign o_in_stall = r_a_valid && !free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign dim_wr     = i_cfg_we &&
                        ((i_cfg_idx == CFG_IMAGE_WIDTH) || (i_cfg_idx == CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= RST_IMAGE_WIDTH;
            r_cfg_h  <= RST_IMAGE_HEIGHT;
            r_cfg_cc <= RST_CHANNEL_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:   r_cfg_w  <= i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_cfg_h  <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_cfg_cc <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Raster position advances per accepted item; a dimension write restarts the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (dim_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (x_last) begin
                n_col = '0;
                n_row = y_last ? '0 : y + 1'b1;
            end else begin
                n_col = x + 1'b1;
                n_row = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_left    <= '0;
            r_ul      <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (load) begin
                r_a_valid <= 1'b0;
            end
            if (load) begin
                r_left <= r_a_cur;
                r_ul   <= upper;
            end
        end
    end

    // Which results the item causes is settled at acceptance.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cur             <= cur;
            r_a_px              <= COORD_W'(x);
            r_a_py              <= COORD_W'(y);
            r_a_pend[SLOT_MEAN] <= (x != '0) && (y != '0);
            r_a_pend[SLOT_COL]  <= (y != '0) && x_last;
            r_a_pend[SLOT_ROW]  <= y_last;
            r_a_fdone           <= x_last;
        end
    end

    // Row store: the previous row's pixels, read before this item overwrites its column.
    bb22_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (x),
        .i_wdata (cur),
        .i_re    (in_acc),
        .i_raddr (x),
        .o_rdata (upper)
    );

    always_comb begin
        ld.pend  = r_a_pend;
        ld.px    = r_a_px;
        ld.py    = r_a_py;
        ld.mean  = mean4(r_ul, upper, r_left, r_a_cur) & mask;
        ld.upper = upper & mask;
        ld.cur   = r_a_cur & mask;
        ld.fdone = r_a_fdone;
    end

    bb22_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_ld          (ld),
        .o_free        (free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pix_x       (o_pix_x),
        .o_pix_y       (o_pix_y),
        .o_res0        (o_res0),
        .o_res1        (o_res1),
        .o_res2        (o_res2),
        .o_res3        (o_res3),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < w_eff)
        else $error("column counter outside the frame");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < h_eff)
        else $error("row counter outside the frame");

endmodule

`default_nettype wire

// ----- tb/box_blur_2x2_stream_unit_tb.sv -----
// Self-checking testbench for the 2x2 box filter stream unit, with a built-in pixel predictor.
`timescale 1ns / 1ps

module box_blur_2x2_stream_unit_tb;
    import bb22_pkg::*;

    // The run is bounded by a cycle watchdog.
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int PRINT_CAP     = 40;
    localparam int IDLE_PCT      = 32;
    localparam int RANDOM_PIXELS = 200;
    localparam int EXTREME_PIXELS = 40;

    // Index 3 is not a register; a write there must leave everything as it was.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // One expected output pixel, in the order the block must deliver it.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        logic               last;
        logic               fdone;
    } t_blur_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic [7:0]           i_chan0      = '0;
    logic [7:0]           i_chan1      = '0;
    logic [7:0]           i_chan2      = '0;
    logic [7:0]           i_chan3      = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [COORD_W-1:0]   o_pix_x;
    logic [COORD_W-1:0]   o_pix_y;
    logic [7:0]           o_res0;
    logic [7:0]           o_res1;
    logic [7:0]           o_res2;
    logic [7:0]           o_res3;
    logic                 o_last_of_run;
    logic                 o_frame_done;

    box_blur_2x2_stream_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_chan0       (i_chan0),
        .i_chan1       (i_chan1),
        .i_chan2       (i_chan2),
        .i_chan3       (i_chan3),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pix_x       (o_pix_x),
        .o_pix_y       (o_pix_y),
        .o_res0        (o_res0),
        .o_res1        (o_res1),
        .o_res2        (o_res2),
        .o_res3        (o_res3),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: the register copies, the previous row, the two
    // neighbor pixels and the raster position of the next item.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] p_width;
    logic [CFG_W-1:0] p_height;
    logic [2:0]       p_chans;
    logic [PIX_W-1:0] p_row_mem [MAX_WIDTH];
    logic [PIX_W-1:0] p_left;
    logic [PIX_W-1:0] p_upper_left;
    int unsigned      p_col;
    int unsigned      p_row;

    t_blur_result expected_q[$];

    int in_idle_pct     = IDLE_PCT;
    int out_idle_pct    = IDLE_PCT;
    int hold_req        = 0;
    int hold_left       = 0;
    int mismatch_count  = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int frames_seen     = 0;
    int cycle_count     = 0;

    task automatic model_reset();
        p_width      = RST_IMAGE_WIDTH;
        p_height     = RST_IMAGE_HEIGHT;
        p_chans      = RST_CHANNEL_COUNT;
        p_row_mem    = '{default: '0};
        p_left       = '0;
        p_upper_left = '0;
        p_col        = 0;
        p_row        = 0;
    endtask

    // A size of zero counts as one; anything past the given limit saturates at it.
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] alpha_keep();
        return (p_chans == CC_RGBA) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
    endfunction

    function automatic logic [PIX_W-1:0] box_mean(input logic [PIX_W-1:0] a, b, c, d);
        logic [PIX_W-1:0] avg;
        logic [9:0]       total;
        avg = '0;
        for (int k = 0; k < 4; k++) begin
            total = 10'(a[8*k +: 8]) + 10'(b[8*k +: 8]) + 10'(c[8*k +: 8]) + 10'(d[8*k +: 8]);
            avg[8*k +: 8] = total[9:2];
        end
        return avg;
    endfunction

    function automatic t_blur_result make_result(input int unsigned x, y,
                                                 input logic [PIX_W-1:0] pix,
                                                 input logic last, fdone);
        t_blur_result r;
        r.x     = x[COORD_W-1:0];
        r.y     = y[COORD_W-1:0];
        r.pix   = pix & alpha_keep();
        r.last  = last;
        r.fdone = fdone;
        return r;
    endfunction

    // Size writes restart the frame at the top-left corner.
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                p_width = data;
                p_col   = 0;
                p_row   = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                p_height = data;
                p_col    = 0;
                p_row    = 0;
            end
            CFG_CHANNEL_COUNT: begin
                p_chans = data[2:0];
            end
            default: begin
            end
        endcase
    endtask

    // Works out the output pixels one accepted input pixel releases: the filtered
    // pixel up and to the left, the last-column pixel of the row above, and the
    // pixel itself when it sits in the last row.
    task automatic predict_pixel(input logic [PIX_W-1:0] raw);
        int unsigned      w, h, x, y;
        logic [PIX_W-1:0] cur, above;
        logic             has_mean, has_col, has_row;
        w        = clamp_dim(p_width, MAX_WIDTH);
        h        = clamp_dim(p_height, MAX_HEIGHT);
        x        = (p_col >= w) ? 0 : p_col;
        y        = (p_row >= h) ? 0 : p_row;
        cur      = raw & alpha_keep();
        above    = p_row_mem[x];
        has_mean = (y >= 1) && (x >= 1);
        has_col  = (y >= 1) && (x == w - 1);
        has_row  = (y == h - 1);
        if (has_mean)
            expected_q.push_back(make_result(x - 1, y - 1,
                box_mean(p_upper_left, above, p_left, cur), !has_col && !has_row, 1'b0));
        if (has_col)
            expected_q.push_back(make_result(x, y - 1, above, !has_row, 1'b0));
        if (has_row)
            expected_q.push_back(make_result(x, y, cur, 1'b1, x == w - 1));
        p_upper_left = above;
        p_left       = cur;
        p_row_mem[x] = cur;
        if (x + 1 >= w) begin
            p_col = 0;
            p_row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            p_col = x + 1;
            p_row = y;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and the result checker.
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string what, input logic [31:0] got, want,
                               input t_blur_result ref_pix);
        if (got !== want)
            note_mismatch($sformatf("%s of pixel (%0d,%0d): got %0h, expected %0h",
                                    what, ref_pix.x, ref_pix.y, got, want));
    endtask

    // Every result taken by the receiver is compared with the oldest expected pixel.
    always @(posedge i_clk) begin : check_results
        t_blur_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                note_mismatch($sformatf("result for (%0d,%0d) with no pixel expected",
                                        o_pix_x, o_pix_y));
            end else begin
                want = expected_q.pop_front();
                check_field("x", 32'(o_pix_x), 32'(want.x), want);
                check_field("y", 32'(o_pix_y), 32'(want.y), want);
                check_field("channel 0", 32'(o_res0), 32'(want.pix[7:0]), want);
                check_field("channel 1", 32'(o_res1), 32'(want.pix[15:8]), want);
                check_field("channel 2", 32'(o_res2), 32'(want.pix[23:16]), want);
                check_field("channel 3", 32'(o_res3), 32'(want.pix[31:24]), want);
                check_field("last flag", 32'(o_last_of_run), 32'(want.last), want);
                check_field("frame flag", 32'(o_frame_done), 32'(want.fdone), want);
            end
            results_checked++;
            if (o_frame_done === 1'b1)
                frames_seen++;
        end
    end

    // The receiver stalls at random, or for a long counted stretch when asked to.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_req > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_req - 1;
            hold_req  = 0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Watchdog expired with %0d pixels still expected.", expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one pixel, possibly after a random gap, and waits until it is taken.
    // Valid stays high into the next item when there is no gap.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_chan0    <= pix[7:0];
        i_chan1    <= pix[15:8];
        i_chan2    <= pix[23:16];
        i_chan3    <= pix[31:24];
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    // Random pixels, with whole channels forced to 0 or 255 now and then.
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] pix;
        pix = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 2))
                    0: pix[8*k +: 8] = 8'h00;
                    1: pix[8*k +: 8] = 8'hFF;
                    default: begin
                    end
                endcase
            end
        end
        return pix;
    endfunction

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Items that release no pixel may still be in flight when the queue empties,
    // so settle keeps waiting after that before any register write.
    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, h, cc);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, cc);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // The 64x64 RGBA setting after reset: two full rows and a little more,
    // then the frame is abandoned by the next size write.
    task automatic test_reset_config();
        send_pixels(2 * 64 + 2);
    endtask

    // Single-pixel frames from zero sizes, 2x2 frames at the channel extremes,
    // a one-column frame, RGB masking of the fourth channel and a write to the
    // unused register index.
    task automatic test_corner_frames();
        configure(12'd0, 12'd0, 12'(CC_RGBA));
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA55A_C33C);

        configure(12'd2, 12'd2, 12'd3);
        repeat (4) send_pixel(32'hFFFF_FFFF);

        configure(12'd2, 12'd2, 12'(CC_RGBA));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFEFF_FEFF);

        settle();
        write_reg(CFG_UNUSED_IDX, 12'hFFF);
        send_pixel(32'h55AA_55AA);
        send_pixel(32'hAA55_AA55);
        send_pixel(32'h0102_0304);
        send_pixel(32'hFDFE_FF00);

        configure(12'd1, 12'd3, 12'(CC_RGBA));
        send_pixel(32'h8000_0001);
        send_pixel(32'h7FFF_FFFE);
        send_pixel(32'h1234_5678);
    endtask

    // Oversized width with two rows, then oversized height with one column;
    // both frames are cut short, so the saturated sizes must not end a row
    // or the frame early.
    task automatic test_extreme_sizes();
        configure(12'hFFF, 12'd2, 12'h007);
        send_pixels(EXTREME_PIXELS);
        configure(12'd1, 12'hFFF, 12'hFFC);
        send_pixels(EXTREME_PIXELS);
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while the sender keeps offering; later the sender stops mid-frame
    // until every expected pixel is out, then finishes the frame.
    task automatic test_backpressure();
        configure(12'd6, 12'd4, 12'(CC_RGBA));
        hold_req = 400;
        send_pixels(24);
        send_pixels(9);
        pause_until_drained();
        send_pixels(15);
    endtask

    // Small random frame sizes and channel settings, one to three frames each,
    // the last one sometimes cut short so the next size write restarts it.
    task automatic test_random_frames();
        int unsigned      sent_here, phase, frames, size, count, budget;
        logic [CFG_W-1:0] w_reg, h_reg, cc_reg;
        sent_here = 0;
        phase     = 0;
        budget    = RANDOM_PIXELS;
        while (sent_here < budget) begin
            phase++;
            // Two phases run with neither side idling.
            if (phase == 3) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (phase == 5) begin
                in_idle_pct  = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
            end
            w_reg  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 24))
                                                  : 12'($urandom_range(1, 12));
            h_reg  = 12'($urandom_range(0, 6));
            cc_reg = {9'($urandom_range(0, 511)),
                      ($urandom_range(0, 1) != 0) ? CC_RGBA : 3'($urandom_range(0, 7))};
            configure(w_reg, h_reg, cc_reg);
            size   = clamp_dim(w_reg, MAX_WIDTH) * clamp_dim(h_reg, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0)
                hold_req = $urandom_range(20, 150);
            for (int f = 0; f < frames; f++) begin
                count = (f == frames - 1 && $urandom_range(0, 4) == 0)
                      ? $urandom_range(1, size) : size;
                // The item budget cuts the last frame short when it runs out.
                if (count > budget - sent_here)
                    count = budget - sent_here;
                send_pixels(count);
                sent_here += count;
            end
        end
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_corner_frames();
        test_extreme_sizes();
        test_backpressure();
        test_random_frames();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            note_mismatch($sformatf("%0d expected pixels never came out", expected_q.size()));

        $display("Sent %0d pixels and checked %0d results over %0d completed frames.",
                 pixels_sent, results_checked, frames_seen);
        $display("Sizes ranged from single pixels to partly fed saturated frames, under stalls.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches found.", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
